// ===== sv/twrq_pkg.sv =====
// Package for the task wake-up ready queue: sizes, codes and the word types
// shared by the front end, the back end and the top level. No dependencies.
package twrq_pkg;

  // Sizes of the task table, the ready queue, the lane range and the job queue.
  localparam int NumTasks      = 64;
  localparam int QueueDepth    = 64;
  localparam int NumLanes      = 16;
  localparam int JobQueueDepth = 2;

  // Widths fixed by the command and result words.
  localparam int TaskW   = 6;
  localparam int HandleW = 16;
  localparam int LaneW   = 4;
  localparam int CountW  = 64;

  // Derived widths.
  localparam int QPtrW   = $clog2(QueueDepth);
  localparam int QCntW   = $clog2(QueueDepth + 1);
  localparam int JqPtrW  = (JobQueueDepth > 1) ? $clog2(JobQueueDepth) : 1;
  localparam int JqCntW  = $clog2(JobQueueDepth + 1);

  // Operation codes of the command word.
  typedef enum logic [2:0] {
    OP_INIT          = 3'd0,
    OP_BEGIN_SUSPEND = 3'd1,
    OP_WAKE          = 3'd2,
    OP_COMMIT        = 3'd3,
    OP_CANCEL        = 3'd4,
    OP_COMPLETE      = 3'd5,
    OP_HELP          = 3'd6,
    OP_QUERY_DONE    = 3'd7
  } op_e;

  // Phase of one task slot.
  typedef enum logic [2:0] {
    PH_UNINIT     = 3'd0,
    PH_RUNNING    = 3'd1,
    PH_SUSPENDING = 3'd2,
    PH_SUSPENDED  = 3'd3,
    PH_NOTIFIED   = 3'd4,
    PH_READY      = 3'd5,
    PH_DONE       = 3'd6
  } phase_e;

  // Status codes of the result word.
  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FAULT     = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_NOT_READY = 2'd3
  } status_e;

  // Command word.
  typedef struct packed {
    logic [2:0]         operation;
    logic [TaskW-1:0]   task_id;
    logic [HandleW-1:0] resume_handle;
    logic [LaneW-1:0]   lane_id;
  } twrq_cmd_t;

  // Result word.
  typedef struct packed {
    logic [1:0]         status;
    logic [TaskW-1:0]   run_task;
    logic [HandleW-1:0] run_handle;
    logic               migrated;
    logic               task_done;
    logic               wake_lanes;
    logic [CountW-1:0]  resume_total;
    logic [CountW-1:0]  migration_total;
  } twrq_rsp_t;

  // Classified command as it travels from the front end to the back end.
  typedef struct packed {
    twrq_cmd_t cmd;
    logic      task_ok;
    logic      lane_ok;
    logic      handle_ok;
  } twrq_job_t;

endpackage

// ===== sv/twrq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module twrq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/twrq_front.sv =====
// Front end: accepts command words, checks their ranges and holds them in a
// short job queue for the back end. Depends on twrq_pkg.
module twrq_front
  import twrq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  twrq_cmd_t cmd_i,
  output logic      job_valid_o,
  output twrq_job_t job_o,
  input  logic      job_pop_i
);

  twrq_job_t             jobs_q [JobQueueDepth];
  logic [JqPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [JqPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [JqCntW-1:0]     cnt_q, cnt_d;
  twrq_job_t             job_new;
  logic                  push;
  logic                  pop;

  // Classify the incoming word: range checks done once, on entry.
  always_comb begin
    job_new.cmd       = cmd_i;
    job_new.task_ok   = int'(cmd_i.task_id) < NumTasks;
    job_new.lane_ok   = int'(cmd_i.lane_id) < NumLanes;
    job_new.handle_ok = cmd_i.resume_handle != '0;
  end

  assign busy        = cnt_q == JqCntW'(JobQueueDepth);
  assign push        = start && !busy;
  assign job_valid_o = cnt_q != '0;
  assign pop         = job_pop_i && job_valid_o;
  assign job_o       = jobs_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == JqPtrW'(JobQueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == JqPtrW'(JobQueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      jobs_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

// ===== sv/twrq_back.sv =====
// Back end: runs one job at a time against the phase, handle and origin
// tables and the ready queue, and issues the result word.
// Depends on twrq_pkg and twrq_ram.
module twrq_back
  import twrq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  twrq_job_t job_i,
  output logic      job_pop_o,
  output logic      rsp_valid_o,
  output twrq_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POP  = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  state_e               state_q, state_d;
  twrq_job_t            job_q, job_d;
  logic [NumTasks-1:0]  valid_q;
  logic                 ph_vld_q, ph_vld_d;
  logic [TaskW-1:0]     pop_task_q;
  logic [QPtrW-1:0]     head_q, head_d;
  logic [QPtrW-1:0]     tail_q, tail_d;
  logic [QCntW-1:0]     count_q, count_d;
  logic [CountW-1:0]    resume_q, resume_d;
  logic [CountW-1:0]    migr_q, migr_d;
  logic                 rsp_valid_q;
  twrq_rsp_t            rsp_q, rsp_d;

  // Table and queue ports.
  logic [TaskW-1:0]   tbl_raddr;
  logic [TaskW-1:0]   tbl_waddr;
  logic               ph_we;
  phase_e             ph_wdata;
  logic [2:0]         ph_rdata;
  logic               hd_we;
  logic [HandleW-1:0] hd_wdata;
  logic [HandleW-1:0] hd_rdata;
  logic               org_we;
  logic [LaneW-1:0]   org_rdata;
  logic               push;
  logic               pop;
  logic [TaskW-1:0]   fifo_rdata;

  phase_e ph;
  logic   exec;
  logic   full;

  assign exec = state_q == ST_EXEC;
  assign full = count_q == QCntW'(QueueDepth);

  // Sequencer: take a job, read the tables, and for a help with a valid lane and
  // a non-empty queue first read the queue head and then the popped task's entries.
  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    job_pop_o = 1'b0;
    ph_vld_d  = ph_vld_q;
    tbl_raddr = job_i.cmd.task_id;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          ph_vld_d  = valid_q[job_i.cmd.task_id];
          if (op_e'(job_i.cmd.operation) == OP_HELP && job_i.lane_ok && count_q != '0) begin
            state_d = ST_POP;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_POP: begin
        tbl_raddr = fifo_rdata;
        ph_vld_d  = valid_q[fifo_rdata];
        state_d   = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Execution of the job against the values just read.
  always_comb begin
    ph        = ph_vld_q ? phase_e'(ph_rdata) : PH_UNINIT;
    rsp_d     = '0;
    rsp_d.status = STS_OK;
    ph_we     = 1'b0;
    ph_wdata  = PH_RUNNING;
    hd_we     = 1'b0;
    hd_wdata  = job_q.cmd.resume_handle;
    org_we    = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    tbl_waddr = job_q.cmd.task_id;
    resume_d  = resume_q;
    migr_d    = migr_q;
    if (op_e'(job_q.cmd.operation) != OP_HELP && !job_q.task_ok) begin
      rsp_d.status = STS_FAULT;
    end else begin
      case (op_e'(job_q.cmd.operation))
        OP_INIT: begin
          if (!job_q.lane_ok) begin
            rsp_d.status = STS_FAULT;
          end else begin
            ph_we    = 1'b1;
            ph_wdata = PH_RUNNING;
            hd_we    = 1'b1;
            hd_wdata = '0;
            org_we   = 1'b1;
          end
        end
        OP_BEGIN_SUSPEND: begin
          if (!job_q.handle_ok || ph != PH_RUNNING) begin
            rsp_d.status = STS_FAULT;
          end else begin
            hd_we    = 1'b1;
            ph_we    = 1'b1;
            ph_wdata = PH_SUSPENDING;
          end
        end
        OP_WAKE: begin
          if (ph == PH_SUSPENDING) begin
            ph_we    = 1'b1;
            ph_wdata = PH_NOTIFIED;
          end else if (ph == PH_SUSPENDED && !full) begin
            ph_we            = 1'b1;
            ph_wdata         = PH_READY;
            push             = 1'b1;
            rsp_d.wake_lanes = 1'b1;
          end else begin
            rsp_d.status = STS_FAULT;
          end
        end
        OP_COMMIT: begin
          if (ph == PH_SUSPENDING) begin
            ph_we    = 1'b1;
            ph_wdata = PH_SUSPENDED;
          end else if (ph == PH_NOTIFIED && !full) begin
            ph_we            = 1'b1;
            ph_wdata         = PH_READY;
            push             = 1'b1;
            rsp_d.wake_lanes = 1'b1;
          end else begin
            rsp_d.status = STS_FAULT;
          end
        end
        OP_CANCEL: begin
          if (ph == PH_SUSPENDING) begin
            ph_we    = 1'b1;
            ph_wdata = PH_RUNNING;
          end else begin
            rsp_d.status = STS_FAULT;
          end
        end
        OP_COMPLETE: begin
          if (ph == PH_RUNNING) begin
            ph_we            = 1'b1;
            ph_wdata         = PH_DONE;
            rsp_d.wake_lanes = 1'b1;
          end else begin
            rsp_d.status = STS_FAULT;
          end
        end
        OP_HELP: begin
          tbl_waddr = pop_task_q;
          if (!job_q.lane_ok) begin
            rsp_d.status = STS_FAULT;
          end else if (count_q == '0) begin
            rsp_d.status = STS_EMPTY;
          end else begin
            pop = 1'b1;
            if (int'(pop_task_q) >= NumTasks || ph != PH_READY) begin
              rsp_d.status = STS_NOT_READY;
            end else begin
              ph_we    = 1'b1;
              ph_wdata = PH_RUNNING;
              if (org_rdata != job_q.cmd.lane_id) begin
                migr_d         = migr_q + 1'b1;
                rsp_d.migrated = 1'b1;
              end
              resume_d         = resume_q + 1'b1;
              rsp_d.run_task   = pop_task_q;
              rsp_d.run_handle = hd_rdata;
            end
          end
        end
        default: begin
          rsp_d.task_done = ph == PH_DONE;
        end
      endcase
    end
    rsp_d.resume_total    = resume_d;
    rsp_d.migration_total = migr_d;
  end

  // Ready queue pointers.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (exec && push) begin
      tail_d  = (tail_q == QPtrW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
    if (exec && pop) begin
      head_d  = (head_q == QPtrW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  // Control state, phase valid bits and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      resume_q    <= '0;
      migr_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      rsp_valid_q <= exec;
      if (exec) begin
        resume_q <= resume_d;
        migr_q   <= migr_d;
      end
      if (exec && ph_we) begin
        valid_q[tbl_waddr] <= 1'b1;
      end
    end
  end

  // Job, read qualifiers and result word.
  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    ph_vld_q <= ph_vld_d;
    if (state_q == ST_POP) begin
      pop_task_q <= fifo_rdata;
    end
    if (exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Phase table; unwritten slots read as uninitialized via the valid bits.
  twrq_ram #(.Width(3), .Depth(NumTasks)) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (exec && ph_we),
    .waddr_i (tbl_waddr),
    .wdata_i (3'(ph_wdata)),
    .raddr_i (tbl_raddr),
    .rdata_o (ph_rdata)
  );

  // Resume handle table.
  twrq_ram #(.Width(HandleW), .Depth(NumTasks)) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (exec && hd_we),
    .waddr_i (tbl_waddr),
    .wdata_i (hd_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (hd_rdata)
  );

  // Origin lane table.
  twrq_ram #(.Width(LaneW), .Depth(NumTasks)) u_origin_ram (
    .clk_i   (clk_i),
    .we_i    (exec && org_we),
    .waddr_i (tbl_waddr),
    .wdata_i (job_q.cmd.lane_id),
    .raddr_i (tbl_raddr),
    .rdata_o (org_rdata)
  );

  // Ready queue storage.
  twrq_ram #(.Width(TaskW), .Depth(QueueDepth)) u_ready_ram (
    .clk_i   (clk_i),
    .we_i    (exec && push),
    .waddr_i (tail_q),
    .wdata_i (job_q.cmd.task_id),
    .raddr_i (head_q),
    .rdata_o (fifo_rdata)
  );

endmodule

// ===== sv/task_wakeup_ready_queue.sv =====
// Top level of the task wake-up ready queue: front end, job queue and back end.
// Depends on twrq_pkg, twrq_front, twrq_back and twrq_ram.
//
//   channel   | handshake               | word
//   ----------+-------------------------+------------------------
//   command   | start (in), busy (out)  | cmd_i  (twrq_cmd_t)
//   result    | rsp_valid_o (strobe)    | rsp_o  (twrq_rsp_t)
//
// A word is taken at a clock edge with start high and busy low and enters the
// job queue; the back end takes it from that queue once it is idle. The back end
// runs one job at a time: the tables are read, then the job executes; a help that
// pops (valid lane, non-empty queue) first reads the queue head, then the tables.
// The result word and its strobe are registered from the execute state. The
// front end holds up to two words, so commands keep coming in while a job runs;
// busy rises only when that queue is full. Reset clears all phases to
// uninitialized, empties the ready queue and zeroes both counters.
// The result strobe lasts one cycle and cannot be held off.
module task_wakeup_ready_queue
  import twrq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  twrq_cmd_t cmd_i,
  output logic      rsp_valid_o,
  output twrq_rsp_t rsp_o
);

  logic      job_valid;
  twrq_job_t job;
  logic      job_pop;

  twrq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  twrq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the task wake-up ready queue.
// Depends on twrq_pkg and the task_wakeup_ready_queue top level. Commands go
// through a directed table and then random task lifecycles; each result word
// is checked against an in-bench scheduler predictor or a typed row's own word.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twrq_pkg::*;

  localparam int RandomWords = 1650;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 12;
  localparam int MaxPrints   = 40;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  twrq_cmd_t cmd_i;
  logic      rsp_valid_o;
  twrq_rsp_t rsp_o;

  task_wakeup_ready_queue u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  // Predictor state: phase, handle and origin per task, plus the ready ring.
  phase_e             tsk_phase  [NumTasks];
  logic [HandleW-1:0] tsk_handle [NumTasks];
  logic [LaneW-1:0]   tsk_origin [NumTasks];
  logic [TaskW-1:0]   ready_ring [QueueDepth];
  int                 ring_head;
  int                 ring_tail;
  int                 ring_fill;
  logic [CountW-1:0]  resumes;
  logic [CountW-1:0]  migrations;

  // Result words still awaited from the block, oldest first.
  twrq_rsp_t sched_outcomes [$];

  // Directed table.
  twrq_cmd_t dir_cmds  [$];
  bit        dir_typed [$];
  twrq_rsp_t dir_rsps  [$];

  int          n_errors;
  int          n_results;
  int          n_words;
  int          n_full_faults;
  int          n_stale_pops;
  int          max_fill;
  int unsigned cyc_count;

  // Clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (n_errors < MaxPrints)
      $display("tb: mismatch on result %0d: %s got %0h, expected %0h",
               n_results, what, got, want);
    n_errors++;
  endtask

  function automatic twrq_cmd_t mk_cmd(input op_e op, input int tid,
                                       input int handle, input int lane);
    twrq_cmd_t c;
    c.operation     = op;
    c.task_id       = tid[TaskW-1:0];
    c.resume_handle = handle[HandleW-1:0];
    c.lane_id       = lane[LaneW-1:0];
    return c;
  endfunction

  // Result word with no task to run and both counters still at zero.
  function automatic twrq_rsp_t mk_rsp(input status_e st, input bit done,
                                       input bit wake);
    twrq_rsp_t r;
    r            = '0;
    r.status     = st;
    r.task_done  = done;
    r.wake_lanes = wake;
    return r;
  endfunction

  // Pushes one task id onto the ready ring; returns 0 when the ring is full.
  function automatic bit ring_push(input logic [TaskW-1:0] tid);
    if (ring_fill >= QueueDepth) begin
      n_full_faults++;
      return 1'b0;
    end
    ready_ring[ring_tail] = tid;
    ring_tail = (ring_tail + 1) % QueueDepth;
    ring_fill++;
    if (ring_fill > max_fill) max_fill = ring_fill;
    return 1'b1;
  endfunction

  // Scheduler predictor: applies one command word and forms its result word.
  task automatic advance_scheduler(input twrq_cmd_t c, output twrq_rsp_t r);
    op_e              op;
    phase_e           ph;
    int               tid;
    logic [TaskW-1:0] popped;
    r   = '0;
    r.status = STS_OK;
    op  = op_e'(c.operation);
    tid = int'(c.task_id);
    ph  = (tid < NumTasks) ? tsk_phase[tid] : PH_UNINIT;
    if (op != OP_HELP && tid >= NumTasks) begin
      r.status = STS_FAULT;
    end else begin
      case (op)
        OP_INIT: begin
          if (int'(c.lane_id) >= NumLanes) begin
            r.status = STS_FAULT;
          end else begin
            tsk_phase[tid]  = PH_RUNNING;
            tsk_handle[tid] = '0;
            tsk_origin[tid] = c.lane_id;
          end
        end
        OP_BEGIN_SUSPEND: begin
          if (c.resume_handle == '0 || ph != PH_RUNNING) begin
            r.status = STS_FAULT;
          end else begin
            tsk_handle[tid] = c.resume_handle;
            tsk_phase[tid]  = PH_SUSPENDING;
          end
        end
        OP_WAKE: begin
          if (ph == PH_SUSPENDING) begin
            tsk_phase[tid] = PH_NOTIFIED;
          end else if (ph == PH_SUSPENDED && ring_push(c.task_id)) begin
            tsk_phase[tid] = PH_READY;
            r.wake_lanes   = 1'b1;
          end else begin
            r.status = STS_FAULT;
          end
        end
        OP_COMMIT: begin
          if (ph == PH_SUSPENDING) begin
            tsk_phase[tid] = PH_SUSPENDED;
          end else if (ph == PH_NOTIFIED && ring_push(c.task_id)) begin
            tsk_phase[tid] = PH_READY;
            r.wake_lanes   = 1'b1;
          end else begin
            r.status = STS_FAULT;
          end
        end
        OP_CANCEL: begin
          if (ph == PH_SUSPENDING) tsk_phase[tid] = PH_RUNNING;
          else r.status = STS_FAULT;
        end
        OP_COMPLETE: begin
          if (ph == PH_RUNNING) begin
            tsk_phase[tid] = PH_DONE;
            r.wake_lanes   = 1'b1;
          end else begin
            r.status = STS_FAULT;
          end
        end
        OP_HELP: begin
          if (int'(c.lane_id) >= NumLanes) begin
            r.status = STS_FAULT;
          end else if (ring_fill == 0) begin
            r.status = STS_EMPTY;
          end else begin
            popped    = ready_ring[ring_head];
            ring_head = (ring_head + 1) % QueueDepth;
            ring_fill--;
            if (int'(popped) >= NumTasks || tsk_phase[popped] != PH_READY) begin
              // A task that was re-initialized after being queued leaves a
              // stale entry: it is consumed and nothing runs.
              r.status = STS_NOT_READY;
              n_stale_pops++;
            end else begin
              tsk_phase[popped] = PH_RUNNING;
              if (tsk_origin[popped] != c.lane_id) begin
                migrations = migrations + 1;
                r.migrated = 1'b1;
              end
              resumes      = resumes + 1;
              r.run_task   = popped;
              r.run_handle = tsk_handle[popped];
            end
          end
        end
        default: begin
          r.task_done = (ph == PH_DONE);
        end
      endcase
    end
    r.resume_total    = resumes;
    r.migration_total = migrations;
  endtask

  // Picks the next random command. Unless the help rate is high, most words advance
  // a task along its lifecycle; the rest are help calls and unconstrained noise.
  function automatic twrq_cmd_t next_command(input int help_pct, input int pool_lo,
                                             input int pool_sz);
    twrq_cmd_t c;
    int        roll;
    int        pick;
    int        tid;
    c.operation     = OP_QUERY_DONE;
    c.lane_id       = LaneW'($urandom);
    c.resume_handle = HandleW'($urandom_range(65535, 1));
    if ($urandom_range(15) == 0)
      c.resume_handle = $urandom_range(1) ? '1 : HandleW'(1);
    tid       = (pool_lo + $urandom_range(pool_sz - 1)) % NumTasks;
    c.task_id = tid[TaskW-1:0];
    roll      = $urandom_range(99);
    pick      = $urandom_range(9);
    if (roll < 12) begin
      c.operation = 3'($urandom);
      c.task_id   = TaskW'($urandom);
      if ($urandom_range(3) == 0) c.resume_handle = '0;
    end else if (roll < 12 + help_pct) begin
      c.operation = OP_HELP;
    end else begin
      case (tsk_phase[tid])
        PH_UNINIT:     c.operation = OP_INIT;
        PH_DONE:       c.operation = (pick < 8) ? OP_INIT : OP_QUERY_DONE;
        PH_RUNNING:    c.operation = (pick < 6) ? OP_BEGIN_SUSPEND :
                                     (pick < 8) ? OP_COMPLETE : OP_QUERY_DONE;
        PH_SUSPENDING: c.operation = (pick < 4) ? OP_WAKE :
                                     (pick < 8) ? OP_COMMIT : OP_CANCEL;
        PH_SUSPENDED:  c.operation = OP_WAKE;
        PH_NOTIFIED:   c.operation = OP_COMMIT;
        default:       c.operation = (pick < 3) ? OP_INIT : OP_HELP;
      endcase
    end
    return c;
  endfunction

  // Drives one command word, waits for it to be taken and records what the
  // block should answer. Called at a falling edge; returns at a falling edge.
  task automatic issue_word(input twrq_cmd_t c, input bit typed,
                            input twrq_rsp_t typed_rsp, input bit may_idle);
    twrq_rsp_t pred;
    while (may_idle && $urandom_range(99) < 18) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    advance_scheduler(c, pred);
    sched_outcomes.push_back(typed ? typed_rsp : pred);
    n_words++;
    @(negedge clk_i);
  endtask

  // Result checker: every strobed word is compared with the oldest expectation.
  always @(posedge clk_i) begin
    twrq_rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (sched_outcomes.size() == 0) begin
        note_mismatch("result word with nothing awaited", 64'(rsp_o.status), 64'(0));
      end else begin
        want = sched_outcomes.pop_front();
        if (rsp_o.status !== want.status)
          note_mismatch("status", 64'(rsp_o.status), 64'(want.status));
        if (rsp_o.run_task !== want.run_task)
          note_mismatch("run_task", 64'(rsp_o.run_task), 64'(want.run_task));
        if (rsp_o.run_handle !== want.run_handle)
          note_mismatch("run_handle", 64'(rsp_o.run_handle), 64'(want.run_handle));
        if (rsp_o.migrated !== want.migrated)
          note_mismatch("migrated", 64'(rsp_o.migrated), 64'(want.migrated));
        if (rsp_o.task_done !== want.task_done)
          note_mismatch("task_done", 64'(rsp_o.task_done), 64'(want.task_done));
        if (rsp_o.wake_lanes !== want.wake_lanes)
          note_mismatch("wake_lanes", 64'(rsp_o.wake_lanes), 64'(want.wake_lanes));
        if (rsp_o.resume_total !== want.resume_total)
          note_mismatch("resume_total", rsp_o.resume_total, want.resume_total);
        if (rsp_o.migration_total !== want.migration_total)
          note_mismatch("migration_total", rsp_o.migration_total,
                        want.migration_total);
        n_results++;
      end
    end
  end

  // Adds one directed row; typed rows carry their own expected word.
  task automatic add_row(input twrq_cmd_t c, input bit typed, input twrq_rsp_t r);
    dir_cmds.push_back(c);
    dir_typed.push_back(typed);
    dir_rsps.push_back(r);
  endtask

  // Main sequence: reset, directed table, random lifecycles, drain, verdict.
  initial begin
    twrq_rsp_t none;
    int        help_pct;
    int        pool_lo;
    int        pool_sz;
    none          = '0;
    rst_ni        = 1'b0;
    start        <= 1'b0;
    cmd_i        <= '0;
    cyc_count     = 0;
    n_errors      = 0;
    n_results     = 0;
    n_words       = 0;
    n_full_faults = 0;
    n_stale_pops  = 0;
    max_fill      = 0;
    ring_head     = 0;
    ring_tail     = 0;
    ring_fill     = 0;
    resumes       = '0;
    migrations    = '0;
    for (int i = 0; i < NumTasks; i++) begin
      tsk_phase[i]  = PH_UNINIT;
      tsk_handle[i] = '0;
      tsk_origin[i] = '0;
    end

    // Right after reset: empty queue, uninitialized tasks, null handle.
    add_row(mk_cmd(OP_HELP, 0, 0, 0), 1'b1, mk_rsp(STS_EMPTY, 1'b0, 1'b0));
    add_row(mk_cmd(OP_QUERY_DONE, 0, 0, 0), 1'b1, mk_rsp(STS_OK, 1'b0, 1'b0));
    add_row(mk_cmd(OP_WAKE, 63, 0, 15), 1'b1, mk_rsp(STS_FAULT, 1'b0, 1'b0));
    add_row(mk_cmd(OP_BEGIN_SUSPEND, 5, 16'h1234, 3), 1'b1,
            mk_rsp(STS_FAULT, 1'b0, 1'b0));
    add_row(mk_cmd(OP_INIT, 0, 0, 0), 1'b1, mk_rsp(STS_OK, 1'b0, 1'b0));
    add_row(mk_cmd(OP_BEGIN_SUSPEND, 0, 0, 0), 1'b1, mk_rsp(STS_FAULT, 1'b0, 1'b0));
    // Wake while suspending is remembered, then the commit enqueues.
    add_row(mk_cmd(OP_BEGIN_SUSPEND, 0, 16'hFFFF, 0), 1'b0, none);
    add_row(mk_cmd(OP_WAKE, 0, 0, 0), 1'b0, none);
    add_row(mk_cmd(OP_COMMIT, 0, 0, 0), 1'b0, none);
    add_row(mk_cmd(OP_HELP, 0, 0, 15), 1'b0, none);
    // Cancel, then suspend fully and wake from suspended.
    add_row(mk_cmd(OP_INIT, 63, 0, 15), 1'b0, none);
    add_row(mk_cmd(OP_BEGIN_SUSPEND, 63, 16'h0001, 0), 1'b0, none);
    add_row(mk_cmd(OP_CANCEL, 63, 0, 0), 1'b0, none);
    add_row(mk_cmd(OP_BEGIN_SUSPEND, 63, 16'h8000, 0), 1'b0, none);
    add_row(mk_cmd(OP_COMMIT, 63, 0, 0), 1'b0, none);
    add_row(mk_cmd(OP_WAKE, 63, 0, 0), 1'b0, none);
    // Re-init of a queued task leaves a stale entry for help to consume.
    add_row(mk_cmd(OP_INIT, 63, 0, 15), 1'b0, none);
    add_row(mk_cmd(OP_HELP, 0, 0, 15), 1'b0, none);
    add_row(mk_cmd(OP_COMPLETE, 63, 0, 0), 1'b0, none);
    add_row(mk_cmd(OP_QUERY_DONE, 63, 0, 0), 1'b0, none);
    add_row(mk_cmd(OP_CANCEL, 63, 0, 0), 1'b0, none);
    add_row(mk_cmd(OP_COMMIT, 0, 0, 0), 1'b0, none);
    add_row(mk_cmd(OP_HELP, 0, 16'hFFFF, 0), 1'b0, none);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_cmds[i]) issue_word(dir_cmds[i], dir_typed[i], dir_rsps[i], 1'b1);

    // Random part in segments of varying help rate and task pool size, so
    // that some segments let the ready queue fill up.
    help_pct = 20;
    pool_lo  = 0;
    pool_sz  = 16;
    for (int i = 0; i < RandomWords; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(2))
          0:       help_pct = 3;
          1:       help_pct = 20;
          default: help_pct = 45;
        endcase
        case ($urandom_range(2))
          0:       pool_sz = 4;
          1:       pool_sz = 16;
          default: pool_sz = NumTasks;
        endcase
        pool_lo = $urandom_range(NumTasks - 1);
      end
      issue_word(next_command(help_pct, pool_lo, pool_sz), 1'b0, none,
                 !(i >= 700 && i < 1050));
    end
    start <= 1'b0;

    // Drain: wait for every awaited word, then allow for any late strobe.
    while (sched_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sched_outcomes.size() != 0)
      note_mismatch("result words never delivered", 64'(sched_outcomes.size()),
                    64'(0));

    $display("tb: %0d command words, %0d result words checked, %0d resumes",
             n_words, n_results, resumes);
    $display("tb: ready queue peak %0d, %0d full-queue faults, %0d stale pops",
             max_fill, n_full_faults, n_stale_pops);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
